// ===== src/rv32i_instruction_executor_core_macros.svh =====
// Assertion macros shared by the executor RTL.
`ifndef RV32I_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RV32IE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("executor assertion failed");

// Antecedent implies consequent in the next cycle.
`define RV32IE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("executor assertion failed");

`endif

// ===== src/rv32ie_pkg.sv =====
// Types, codes and helper functions of the RV32I executor.
package rv32ie_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int NUM_REGS_DEF  = 32;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ECALL  = 3'd1;
  localparam logic [2:0] ST_EBREAK = 3'd2;
  localparam logic [2:0] ST_UNSUP  = 3'd3;
  localparam logic [2:0] ST_BOUNDS = 3'd4;
  localparam logic [2:0] ST_MISAL  = 3'd5;
  localparam logic [2:0] ST_PCEND  = 3'd6;
  localparam logic [2:0] ST_HALTED = 3'd7;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0]  F7_BASE = 7'h00;
  localparam logic [6:0]  F7_ALT  = 7'h20;
  localparam logic [31:0] UIMM_MASK   = 32'hFFFFF000;
  localparam logic [31:0] ECALL_WORD  = 32'h00000073;
  localparam logic [31:0] EBREAK_WORD = 32'h00100073;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SW  = 3'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction;
    logic [13:0] preload_word_address;
    logic [31:0] preload_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } out_word_t;

  typedef struct packed {
    logic [3:0]      we;
    logic            re;
    logic [3:0][7:0] wdata;
  } dmem_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] res;
  } alu_res_t;

  function automatic alu_res_t alu_op(input logic [2:0] f3, input logic [6:0] f7,
                                      input logic [31:0] a, input logic [31:0] b,
                                      input logic reg_form);
    alu_res_t   r;
    logic [4:0] sh;
    r.ok  = 1'b1;
    r.res = '0;
    sh    = b[4:0];
    case (f3)
      F3_ADD: begin
        if (reg_form && f7 == F7_ALT) r.res = a - b;
        else r.res = a + b;
        if (reg_form && f7 != F7_BASE && f7 != F7_ALT) r.ok = 1'b0;
      end
      F3_SLL: begin
        r.res = a << sh;
        if (f7 != F7_BASE) r.ok = 1'b0;
      end
      F3_SR: begin
        if (f7 == F7_ALT) r.res = 32'($signed(a) >>> sh);
        else r.res = a >> sh;
        if (f7 != F7_BASE && f7 != F7_ALT) r.ok = 1'b0;
      end
      F3_SLT:  r.res = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: r.res = {31'd0, a < b};
      F3_XOR:  r.res = a ^ b;
      F3_OR:   r.res = a | b;
      default: r.res = a & b;
    endcase
    if (reg_form && f7 != F7_BASE && f3 != F3_ADD && f3 != F3_SLL && f3 != F3_SR)
      r.ok = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/rv32i_instruction_executor_core.sv =====
// Top level of the RV32I executor: decode, execute, load write-back and output register.
// One word executes one instruction or preloads one data memory word. Non-load words are
// taken one per cycle while the output is not stalled; each result passes from the execute
// register to the output register. A load goes from execute through the data memory read
// port register to the output register, and no word is taken until its result has left the
// read stage. A stalled result holds the word in execute and stalls the input. After reset
// the data memory is cleared one row of four bytes per cycle, and no word is taken while
// it clears; configuration writes are taken in every cycle out of reset.
`include "rv32i_instruction_executor_core_macros.svh"

module rv32i_instruction_executor_core #(
  parameter int MEM_BYTES = rv32ie_pkg::MEM_BYTES_DEF,
  parameter int NUM_REGS  = rv32ie_pkg::NUM_REGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rv32ie_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rv32ie_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);
  import rv32ie_pkg::*;

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int RW  = AW - 2;
  localparam int RAW = $clog2(NUM_REGS);

  logic        s1_valid_r, s1_valid_nxt;
  in_word_t    s1_item_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic [4:0]  s2_rd_r;
  logic [2:0]  s2_f3_r;
  logic [1:0]  s2_off_r;
  logic [31:0] s2_npc_r;
  logic [31:0] pc_r;
  logic        halted_r;
  logic        allow_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic        acc, out_free, s1_leave, s1_to_s2, s2_done, clr_busy;
  logic [31:0] rs1_val, rs2_val;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;

  logic [31:0] ins, immi, imms, immb, immj, ea, pl_base, maddr, mdata;
  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3, size, msize;
  logic [1:0]  off, lidx;
  logic        oob, misal, pc_end, pl_oob;
  alu_res_t    alu;
  logic [2:0]  ex_st;
  logic [31:0] ex_npc, ex_wval;
  logic        ex_wr, ex_ld, ex_halt, ex_pcupd, ex_rfwe, take;
  logic [3:0]  ex_mwe;
  dmem_req_t   mreq;
  logic [3:0][RW-1:0] mrow;
  logic [3:0][7:0]    mrd;
  logic [31:0] ld_word, ld_val;

  assign ins  = s1_item_r.instruction;
  assign op   = ins[6:0];
  assign rd   = ins[11:7];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  assign ea      = rs1_val + ((op == OPC_STORE) ? imms : immi);
  assign size    = 3'd1 << f3[1:0];
  assign oob     = ({1'b0, ea} + 33'(size)) > 33'(MEM_BYTES);
  assign misal   = !allow_r && ((size == 3'd2 && ea[0]) || (size == 3'd4 && ea[1:0] != 2'd0));
  assign pc_end  = ({1'b0, pc_r} + 33'd3) >= 33'(MEM_BYTES);
  assign pl_base = {16'd0, s1_item_r.preload_word_address, 2'b00};
  assign pl_oob  = ({1'b0, pl_base} + 33'd4) > 33'(MEM_BYTES);

  always_comb begin
    alu = alu_op(f3, f7, rs1_val, (op == OPC_OP) ? rs2_val :
                 ((f3 == F3_SLL || f3 == F3_SR) ? {27'd0, ins[24:20]} : immi),
                 op == OPC_OP);
  end

  always_comb begin
    ex_st    = ST_OK;
    ex_npc   = pc_r + 32'd4;
    ex_wr    = 1'b0;
    ex_wval  = '0;
    ex_ld    = 1'b0;
    ex_mwe   = 4'b0000;
    ex_halt  = 1'b0;
    ex_pcupd = 1'b0;
    take     = 1'b0;
    if (s1_item_r.operation) begin
      ex_npc = pc_r;
      if (pl_oob) ex_st = ST_BOUNDS;
      else begin
        ex_mwe = 4'b1111;
        ex_st  = halted_r ? ST_HALTED : ST_OK;
      end
    end else if (halted_r) begin
      ex_st  = ST_HALTED;
      ex_npc = pc_r;
    end else if (pc_end) begin
      ex_st   = ST_PCEND;
      ex_npc  = pc_r;
      ex_halt = 1'b1;
    end else begin
      case (op)
        OPC_LUI: begin
          ex_wr   = 1'b1;
          ex_wval = ins & UIMM_MASK;
        end
        OPC_AUIPC: begin
          ex_wr   = 1'b1;
          ex_wval = pc_r + (ins & UIMM_MASK);
        end
        OPC_JAL: begin
          ex_wr   = 1'b1;
          ex_wval = pc_r + 32'd4;
          ex_npc  = pc_r + immj;
        end
        OPC_JALR: begin
          if (f3 != F3_ADD) ex_st = ST_UNSUP;
          ex_wr   = 1'b1;
          ex_wval = pc_r + 32'd4;
          ex_npc  = (rs1_val + immi) & ~32'd1;
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  take = rs1_val == rs2_val;
            F3_BNE:  take = rs1_val != rs2_val;
            F3_BLT:  take = $signed(rs1_val) < $signed(rs2_val);
            F3_BGE:  take = $signed(rs1_val) >= $signed(rs2_val);
            F3_BLTU: take = rs1_val < rs2_val;
            F3_BGEU: take = rs1_val >= rs2_val;
            default: ex_st = ST_UNSUP;
          endcase
          if (take) ex_npc = pc_r + immb;
        end
        OPC_LOAD: begin
          if (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})) ex_st = ST_UNSUP;
          else if (oob) ex_st = ST_BOUNDS;
          else if (misal) ex_st = ST_MISAL;
          else ex_ld = 1'b1;
        end
        OPC_STORE: begin
          if (f3 > F3_SW) ex_st = ST_UNSUP;
          else if (oob) ex_st = ST_BOUNDS;
          else if (misal) ex_st = ST_MISAL;
          else ex_mwe = 4'b1111;
        end
        OPC_OPIMM, OPC_OP: begin
          if (!alu.ok) ex_st = ST_UNSUP;
          ex_wr   = 1'b1;
          ex_wval = alu.res;
        end
        OPC_SYSTEM: begin
          if (ins == ECALL_WORD) ex_st = ST_ECALL;
          else if (ins == EBREAK_WORD) ex_st = ST_EBREAK;
          else ex_st = ST_UNSUP;
        end
        default: ex_st = ST_UNSUP;
      endcase
      if (ex_st != ST_OK) begin
        ex_halt = 1'b1;
        ex_npc  = pc_r;
        ex_wr   = 1'b0;
        ex_ld   = 1'b0;
        ex_mwe  = 4'b0000;
      end else begin
        ex_pcupd = 1'b1;
      end
    end
    ex_rfwe = ex_wr && rd != 5'd0;
  end

  assign maddr = s1_item_r.operation ? pl_base : ea;
  assign mdata = s1_item_r.operation ? s1_item_r.preload_data : rs2_val;
  assign msize = s1_item_r.operation ? 3'd4 : size;
  assign off   = maddr[1:0];

  always_comb begin
    lidx = 2'd0;
    mreq = '0;
    mrow = '0;
    for (int k = 0; k < 4; k++) begin
      lidx          = 2'(k) - off;
      mreq.we[k]    = ex_mwe[k] && (3'(lidx) < msize) && s1_leave && !s1_to_s2;
      mreq.wdata[k] = mdata[{lidx, 3'b000} +: 8];
      mrow[k]       = maddr[AW-1:2] + RW'(2'(k) < off);
    end
    mreq.re = s1_to_s2;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) ld_word[8*i +: 8] = mrd[2'(i) + s2_off_r];
    case (s2_f3_r)
      F3_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      F3_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      F3_LBU:  ld_val = {24'd0, ld_word[7:0]};
      F3_LHU:  ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_to_s2 = s1_valid_r && ex_ld;
  assign s1_leave = s1_valid_r && (ex_ld || out_free);
  assign s2_done  = s2_valid_r && out_free;
  assign in_stall = clr_busy || s2_valid_r || (s1_valid_r && !(s1_leave && !s1_to_s2));
  assign acc      = in_valid && !in_stall;

  assign rf_we    = (s1_leave && !s1_to_s2 && ex_rfwe) || (s2_done && s2_rd_r != 5'd0);
  assign rf_waddr = s2_valid_r ? s2_rd_r : rd;
  assign rf_wdata = s2_valid_r ? ld_val : ex_wval;

  always_comb begin
    s1_valid_nxt  = acc || (s1_valid_r && !s1_leave);
    s2_valid_nxt  = s1_to_s2 || (s2_valid_r && !s2_done);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (s1_leave && !s1_to_s2) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = ex_st;
      out_data_nxt.next_pc   = ex_npc;
      out_data_nxt.reg_write = ex_rfwe;
      out_data_nxt.reg_index = ex_rfwe ? rd : 5'd0;
      out_data_nxt.reg_value = ex_rfwe ? ex_wval : 32'd0;
    end else if (s2_done) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = ST_OK;
      out_data_nxt.next_pc   = s2_npc_r;
      out_data_nxt.reg_write = s2_rd_r != 5'd0;
      out_data_nxt.reg_index = s2_rd_r;
      out_data_nxt.reg_value = (s2_rd_r != 5'd0) ? ld_val : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      allow_r     <= 1'b1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_leave && ex_pcupd) pc_r <= ex_npc;
      if (s1_leave && ex_halt) halted_r <= 1'b1;
      if (cfg_we) allow_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (acc) s1_item_r <= in_data;
    if (s1_to_s2) begin
      s2_rd_r  <= rd;
      s2_f3_r  <= f3;
      s2_off_r <= off;
      s2_npc_r <= ex_npc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rv32ie_regfile #(.NREGS(NUM_REGS)) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (rf_we),
    .waddr  (RAW'(rf_waddr)),
    .wdata  (rf_wdata),
    .re     (acc),
    .raddr1 (RAW'(in_data.instruction[19:15])),
    .raddr2 (RAW'(in_data.instruction[24:20])),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val)
  );

  rv32ie_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .row   (mrow),
    .rdata (mrd),
    .busy  (clr_busy)
  );

  `RV32IE_ASSERT_IMP(a_one_stage_busy, s2_valid_r, !s1_valid_r)
  `RV32IE_ASSERT_NEXT(a_load_to_wb, s1_to_s2, s2_valid_r)
  `RV32IE_ASSERT_IMP(a_no_x0_write, rf_we, rf_waddr != 5'd0)
  `RV32IE_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r)
  `RV32IE_ASSERT_IMP(a_no_take_clearing, clr_busy, in_stall)

endmodule

// ===== src/rv32ie_regfile.sv =====
// Register file with two registered read ports, write bypass and reset valid bits.
module rv32ie_regfile #(
  parameter int NREGS = rv32ie_pkg::NUM_REGS_DEF,
  localparam int AW = $clog2(NREGS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr1,
  input  logic [AW-1:0] raddr2,
  output logic [31:0]   rdata1,
  output logic [31:0]   rdata2
);
  import rv32ie_pkg::*;

  logic [31:0]      mem [NREGS];
  logic [NREGS-1:0] vld_r;
  logic [31:0]      rd1_r, rd2_r, bd_r;
  logic             byp1_r, byp2_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rd1_r <= mem[raddr1];
      rd2_r <= mem[raddr2];
      bd_r  <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      byp1_r <= 1'b0;
      byp2_r <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (re) begin
        byp1_r <= we && waddr == raddr1;
        byp2_r <= we && waddr == raddr2;
        v1_r   <= vld_r[raddr1];
        v2_r   <= vld_r[raddr2];
      end
    end
  end

  assign rdata1 = byp1_r ? bd_r : (v1_r ? rd1_r : 32'd0);
  assign rdata2 = byp2_r ? bd_r : (v2_r ? rd2_r : 32'd0);

endmodule

// ===== src/rv32ie_dmem.sv =====
// Byte-lane data memory with a registered read and a clearing pass after reset.
module rv32ie_dmem #(
  parameter int MEM_BYTES = rv32ie_pkg::MEM_BYTES_DEF,
  localparam int RW = $clog2(MEM_BYTES) - 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rv32ie_pkg::dmem_req_t  req,
  input  logic [3:0][RW-1:0]     row,
  output logic [3:0][7:0]        rdata,
  output logic                   busy
);
  import rv32ie_pkg::*;

  localparam int ROWS = (MEM_BYTES + 3) / 4;

  logic [RW-1:0] cnt_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      cnt_r <= cnt_r + RW'(1);
      if (cnt_r == RW'(ROWS - 1)) busy_r <= 1'b0;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0] mem [ROWS];
    logic [7:0] rd_r;
    always_ff @(posedge clk) begin
      if (busy_r) mem[cnt_r] <= 8'd0;
      else if (req.we[k]) mem[row[k]] <= req.wdata[k];
      if (req.re) rd_r <= mem[row[k]];
    end
    assign rdata[k] = rd_r;
  end

  assign busy = busy_r;

endmodule
